// ===== rtl/core/tfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfrc_pkg
// Shared types and constants for the four-register instruction step core:
// sequencer states, arithmetic op codes and instruction field positions.
// ----------------------------------------------------------------------------
package tfrc_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned RIDX_W = 2;
    localparam int unsigned NUM_REGS = 4;
    localparam int unsigned CNT_W = 3;

    // instruction bit positions
    localparam int unsigned BIT_ALU_N = 7;  // clear: immediate load
    localparam int unsigned BIT_IO = 6;     // set: IN / OUT
    localparam int unsigned BIT_OUT = 2;    // set within IN / OUT: OUT

    localparam logic [RIDX_W-1:0] REG_D = 2'd3;
    localparam logic [CNT_W-1:0] ITER_LAST = 3'd7;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_EXEC   = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

endpackage

// ===== rtl/core/tiny_four_register_cpu_step.sv =====
// ----------------------------------------------------------------------------
// tiny_four_register_cpu_step
// Executes one instruction byte per input beat on four 8-bit registers,
// using one shared 9-bit add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
// Timing: an immediate load or IN completes in the accept cycle and the core
// is ready again next cycle. OUT and a divide by zero pass through accept,
// operand decode and the result stage; ADD and SUB through accept, operand
// decode and one pass through the adder. MUL and DIV pass through accept,
// decode and eight iterations of the shared adder (shift-add for MUL,
// restoring steps for DIV). The register file is read through two registered
// ports in the accept cycle. A result beat sits in an output register, so the
// core takes the next instruction while it waits; a second result waits in the
// emit state until the output register frees up.
module tiny_four_register_cpu_step (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] instr_byte,
    input  logic [7:0] in_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_value,
    output logic       fault
);

    tfrc_pkg::state_t state_reg, state_next;

    logic [tfrc_pkg::DATA_W-1:0]   mem [tfrc_pkg::NUM_REGS];
    logic [tfrc_pkg::NUM_REGS-1:0] mem_ok_reg;
    logic [tfrc_pkg::DATA_W-1:0]   rd_dst_reg, rd_src_reg;
    logic                          rd_dst_ok_reg, rd_src_ok_reg;
    logic [tfrc_pkg::DATA_W-1:0]   opnd_a, opnd_b;

    logic [tfrc_pkg::DATA_W-1:0]   ir_reg;
    tfrc_pkg::op_t                 op_reg, op_next;
    logic [tfrc_pkg::RIDX_W-1:0]   rd_reg, rd_next;
    logic [tfrc_pkg::DATA_W-1:0]   x_reg, x_next;
    logic [tfrc_pkg::DATA_W-1:0]   y_reg, y_next;
    logic [tfrc_pkg::DATA_W-1:0]   q_reg, q_next;
    logic [tfrc_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [tfrc_pkg::DATA_W-1:0]   res_val_reg, res_val_next;
    logic                          res_fault_reg, res_fault_next;

    logic                          out_valid_reg, out_valid_next;
    logic [tfrc_pkg::DATA_W-1:0]   out_value_reg, out_value_next;
    logic                          fault_reg, fault_next;

    logic                          in_fire, is_local;
    logic                          we;
    logic [tfrc_pkg::RIDX_W-1:0]   waddr;
    logic [tfrc_pkg::DATA_W-1:0]   wdata;

    // shared adder
    logic                          alu_sub;
    logic [tfrc_pkg::DATA_W:0]     alu_x, alu_y;
    logic [tfrc_pkg::DATA_W+1:0]   alu_sum;
    logic                          div_ge;

    assign in_stall = (state_reg != tfrc_pkg::S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign is_local = !instr_byte[tfrc_pkg::BIT_ALU_N]
                   || (instr_byte[tfrc_pkg::BIT_IO] && !instr_byte[tfrc_pkg::BIT_OUT]);

    assign opnd_a = rd_dst_ok_reg ? rd_dst_reg : '0;
    assign opnd_b = rd_src_ok_reg ? rd_src_reg : '0;

    assign alu_sub = (op_reg == tfrc_pkg::OP_SUB) || (op_reg == tfrc_pkg::OP_DIV);
    assign alu_x   = (op_reg == tfrc_pkg::OP_DIV) ? {x_reg, q_reg[tfrc_pkg::DATA_W-1]}
                                                  : {1'b0, x_reg};
    assign alu_y   = {1'b0, y_reg};
    assign alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                   + {{(tfrc_pkg::DATA_W+1){1'b0}}, alu_sub};
    // no borrow out of the trial subtract
    assign div_ge  = alu_sum[tfrc_pkg::DATA_W+1];

    // register file: registered read ports, one write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (in_fire)
        begin
            rd_dst_reg <= mem[instr_byte[3:2]];
            rd_src_reg <= mem[instr_byte[1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_ok_reg    <= '0;
            rd_dst_ok_reg <= 1'b0;
            rd_src_ok_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                mem_ok_reg[waddr] <= 1'b1;
            end
            if (in_fire)
            begin
                rd_dst_ok_reg <= mem_ok_reg[instr_byte[3:2]];
                rd_src_ok_reg <= mem_ok_reg[instr_byte[1:0]];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        rd_next        = rd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        res_val_next   = res_val_reg;
        res_fault_next = res_fault_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_value_next = out_value_reg;
        fault_next     = fault_reg;
        we             = 1'b0;
        waddr          = rd_reg;
        wdata          = x_reg;

        unique case (state_reg)
            tfrc_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (is_local)
                    begin
                        we = 1'b1;
                        if (!instr_byte[tfrc_pkg::BIT_ALU_N])
                        begin
                            waddr = tfrc_pkg::REG_D;
                            wdata = {1'b0, instr_byte[6:0]};
                        end
                        else
                        begin
                            waddr = instr_byte[1:0];
                            wdata = in_value;
                        end
                    end
                    else
                    begin
                        state_next = tfrc_pkg::S_DECODE;
                    end
                end
            end

            tfrc_pkg::S_DECODE:
            begin
                op_next = tfrc_pkg::op_t'(ir_reg[5:4]);
                rd_next = ir_reg[3:2];
                if (ir_reg[tfrc_pkg::BIT_IO])
                begin
                    res_val_next   = opnd_b;
                    res_fault_next = 1'b0;
                    state_next     = tfrc_pkg::S_EMIT;
                end
                else
                begin
                    unique case (tfrc_pkg::op_t'(ir_reg[5:4]))
                        tfrc_pkg::OP_ADD, tfrc_pkg::OP_SUB:
                        begin
                            x_next     = opnd_a;
                            y_next     = opnd_b;
                            cnt_next   = '0;
                            state_next = tfrc_pkg::S_EXEC;
                        end
                        tfrc_pkg::OP_MUL:
                        begin
                            x_next     = '0;
                            y_next     = opnd_a;
                            q_next     = opnd_b;
                            cnt_next   = tfrc_pkg::ITER_LAST;
                            state_next = tfrc_pkg::S_EXEC;
                        end
                        tfrc_pkg::OP_DIV:
                        begin
                            if (opnd_b == '0)
                            begin
                                res_val_next   = '0;
                                res_fault_next = 1'b1;
                                state_next     = tfrc_pkg::S_EMIT;
                            end
                            else
                            begin
                                x_next     = '0;
                                y_next     = opnd_b;
                                q_next     = opnd_a;
                                cnt_next   = tfrc_pkg::ITER_LAST;
                                state_next = tfrc_pkg::S_EXEC;
                            end
                        end
                        default:
                        begin
                            state_next = tfrc_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            tfrc_pkg::S_EXEC:
            begin
                unique case (op_reg)
                    tfrc_pkg::OP_ADD, tfrc_pkg::OP_SUB:
                    begin
                        x_next = alu_sum[tfrc_pkg::DATA_W-1:0];
                    end
                    tfrc_pkg::OP_MUL:
                    begin
                        if (q_reg[0])
                        begin
                            x_next = alu_sum[tfrc_pkg::DATA_W-1:0];
                        end
                        y_next = {y_reg[tfrc_pkg::DATA_W-2:0], 1'b0};
                        q_next = {1'b0, q_reg[tfrc_pkg::DATA_W-1:1]};
                    end
                    tfrc_pkg::OP_DIV:
                    begin
                        // partial remainder stays below the divisor
                        x_next = div_ge ? alu_sum[tfrc_pkg::DATA_W-1:0]
                                        : alu_x[tfrc_pkg::DATA_W-1:0];
                        q_next = {q_reg[tfrc_pkg::DATA_W-2:0], div_ge};
                    end
                    default:
                    begin
                        x_next = x_reg;
                    end
                endcase
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    we         = 1'b1;
                    waddr      = rd_reg;
                    wdata      = (op_reg == tfrc_pkg::OP_DIV) ? q_next : x_next;
                    state_next = tfrc_pkg::S_IDLE;
                end
            end

            tfrc_pkg::S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_val_reg;
                    fault_next     = res_fault_reg;
                    state_next     = tfrc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tfrc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfrc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ir_reg <= instr_byte;
        end
        op_reg        <= op_next;
        rd_reg        <= rd_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        q_reg         <= q_next;
        cnt_reg       <= cnt_next;
        res_val_reg   <= res_val_next;
        res_fault_reg <= res_fault_next;
        out_value_reg <= out_value_next;
        fault_reg     <= fault_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign fault     = fault_reg;

    // a fault beat carries a zero value
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault |-> out_value == '0)
        else $error("fault beat with nonzero value");

    // iterations continue until the count runs out
    a_exec_runs: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tfrc_pkg::S_EXEC && cnt_reg != '0 |=> state_reg == tfrc_pkg::S_EXEC)
        else $error("iteration cut short");

    // arithmetic and OUT go through decode, local writes do not
    a_accept_route: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == tfrc_pkg::S_DECODE) == !$past(is_local))
        else $error("wrong route after accept");

    // an immediate load marks register d as written
    a_movi_valid: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !instr_byte[tfrc_pkg::BIT_ALU_N] |=> mem_ok_reg[tfrc_pkg::REG_D])
        else $error("immediate load lost");

endmodule
